FILE: rtl/fxa_pkg.sv
package fxa_pkg;

    typedef enum logic [3:0] {
        FUNC_ADD     = 4'd0,
        FUNC_SUB     = 4'd1,
        FUNC_MUL     = 4'd2,
        FUNC_DIV     = 4'd3,
        FUNC_MIN     = 4'd4,
        FUNC_MAX     = 4'd5,
        FUNC_INC     = 4'd6,
        FUNC_DEC     = 4'd7,
        FUNC_I2F     = 4'd8,
        FUNC_F2I     = 4'd9
    } t_func;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic [3:0]        func;
        logic [DATA_W-1:0] fast;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
        logic              neg;
    } t_side;

endpackage

FILE: rtl/fixed_point_q24_8_alu_unit.sv
// throughput: one beat per cycle; the radix-2 divider is unrolled four steps a stage
// a downstream stall freezes the whole pipe, input ready follows output ready
// reset (synchronous, active low) clears the valid bits only
module fixed_point_q24_8_alu_unit #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_func,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_result,
    output logic        o_a_less,
    output logic        o_a_equal,
    output logic        o_a_greater,
    output logic        o_divide_by_zero
);
    localparam int DW = fxa_pkg::DATA_W;
    localparam int NW = DW + FRACTION_BITS;
    localparam int DST = (NW + 3) / 4;
    localparam int LAT = DST + 2;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = i_ready || !o_valid;
    assign o_ready = en;

    // stage 0: magnitudes, flags and simple ops
    logic [DW-1:0] mag_a, mag_b, fast;
    logic lt, eq, gt, neg;
    fxa_pkg::t_side r_side0;
    logic [DW-1:0] r_ma, r_mb;
    always_comb begin
        mag_a = i_operand_a[DW-1] ? DW'(-i_operand_a) : DW'(i_operand_a);
        mag_b = i_operand_b[DW-1] ? DW'(-i_operand_b) : DW'(i_operand_b);
        lt  = i_operand_a < i_operand_b;
        gt  = i_operand_a > i_operand_b;
        eq  = i_operand_a == i_operand_b;
        neg = i_operand_a[DW-1] ^ i_operand_b[DW-1];
        fast = '0;
        unique case (i_func)
            fxa_pkg::FUNC_ADD: fast = DW'(i_operand_a + i_operand_b);
            fxa_pkg::FUNC_SUB: fast = DW'(i_operand_a - i_operand_b);
            fxa_pkg::FUNC_MIN: fast = lt ? i_operand_a : i_operand_b;
            fxa_pkg::FUNC_MAX: fast = gt ? i_operand_a : i_operand_b;
            fxa_pkg::FUNC_INC: fast = DW'(i_operand_a + 32'sd1);
            fxa_pkg::FUNC_DEC: fast = DW'(i_operand_a - 32'sd1);
            fxa_pkg::FUNC_I2F: fast = DW'(i_operand_a <<< FRACTION_BITS);
            fxa_pkg::FUNC_F2I: begin
                fast = mag_a >> FRACTION_BITS;
                if (i_operand_a[DW-1]) fast = DW'(-fast);
            end
            default: fast = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side0 <= '{func: i_func, fast: fast, lt: lt, eq: eq, gt: gt,
                         dz: (i_func == fxa_pkg::FUNC_DIV) && (i_operand_b == '0),
                         neg: neg};
            r_ma <= mag_a;
            r_mb <= mag_b;
        end
    end

    // stage 1: unsigned product
    logic [2*DW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (en) r_prod <= r_ma * r_mb;
    end

    // divider runs alongside from stage 1
    logic [DW-1:0] quo;
    fxa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_ma),
        .i_den (r_mb),
        .o_quo (quo)
    );

    // side band and product delay line
    fxa_pkg::t_side  r_side [DST];
    logic [DW-1:0]   r_mres [DST-1];
    logic [2*DW-1:0] sp;
    assign sp = r_side[0].neg ? -r_prod : r_prod;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_side0;
            r_mres[0] <= DW'($signed(sp) >>> FRACTION_BITS);
            for (int i = 1; i < DST; i++) begin
                r_side[i] <= r_side[i-1];
            end
            for (int i = 1; i < DST - 1; i++) begin
                r_mres[i] <= r_mres[i-1];
            end
        end
    end

    fxa_pkg::t_side sl;
    logic [DW-1:0] res;
    assign sl = r_side[DST-1];
    always_comb begin
        unique case (sl.func)
            fxa_pkg::FUNC_MUL: res = r_mres[DST-2];
            fxa_pkg::FUNC_DIV: res = sl.dz ? '0 : (sl.neg ? DW'(-quo) : quo);
            default:           res = sl.fast;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_result         <= res;
            o_a_less         <= sl.lt;
            o_a_equal        <= sl.eq;
            o_a_greater      <= sl.gt;
            o_divide_by_zero <= sl.dz;
        end
    end
    assign o_valid = r_vld[LAT-1];

`ifndef ASSERT_OFF
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_less, o_a_equal, o_a_greater}))
        else $error("compare flags not one-hot");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result == '0))
        else $error("divide by zero result not zero");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");
`endif
endmodule

FILE: rtl/fxa_div.sv
module fxa_div #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [fxa_pkg::DATA_W-1:0] i_num,
    input  logic [fxa_pkg::DATA_W-1:0] i_den,
    output logic [fxa_pkg::DATA_W-1:0] o_quo
);
    localparam int NW = fxa_pkg::DATA_W + FRACTION_BITS;
    localparam int STEPS = 4;
    localparam int STG = (NW + STEPS - 1) / STEPS;
    localparam int DW = fxa_pkg::DATA_W;

    logic [NW-1:0] r_q   [1:STG];
    logic [DW:0]   r_rem [1:STG];
    logic [DW-1:0] r_den [1:STG];

    for (genvar s = 0; s < STG; s++) begin : g_stage
        logic [NW-1:0] q_in;
        logic [DW:0]   rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] n_q;
        logic [DW:0]   n_rem;
        logic [DW+1:0] t;
        if (s == 0) begin : g_first
            assign q_in   = {i_num, FRACTION_BITS'(0)};
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign q_in   = r_q[s];
            assign rem_in = r_rem[s];
            assign den_in = r_den[s];
        end
        always_comb begin
            n_q   = q_in;
            n_rem = rem_in;
            t     = '0;
            for (int k = 0; k < STEPS; k++) begin
                if (s * STEPS + k < NW) begin
                    t = {n_rem, n_q[NW-1]} - {2'b00, den_in};
                    n_q = {n_q[NW-2:0], ~t[DW+1]};
                    n_rem = t[DW+1] ? {n_rem[DW-1:0], q_in[NW-1-k]}
                                    : t[DW:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]   <= n_q;
                r_rem[s+1] <= n_rem;
                r_den[s+1] <= den_in;
            end
        end
    end

    assign o_quo = r_q[STG][DW-1:0];
endmodule
